// ===== rtl/dra_pkg.sv =====
package dra_pkg;

   // Result kinds
   localparam logic [1:0] KIND_IPV4   = 2'd0;
   localparam logic [1:0] KIND_IPV6   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Packet status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_SHORT      = 3'd1;
   localparam logic [2:0] ST_BAD_FLAGS  = 3'd2;
   localparam logic [2:0] ST_QCOUNT     = 3'd3;
   localparam logic [2:0] ST_COMPRESSED = 3'd4;
   localparam logic [2:0] ST_TRUNCATED  = 3'd5;

   // Record types and lengths of interest
   localparam logic [15:0] RTYPE_A    = 16'd1;
   localparam logic [15:0] RTYPE_AAAA = 16'd28;
   localparam logic [15:0] RLEN_A     = 16'd4;
   localparam logic [15:0] RLEN_AAAA  = 16'd16;

   // Output queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [63:0] address_upper;
      logic [63:0] address_lower;
      logic [2:0]  parse_status;
      logic        last_result;
   } result_type;

   // Up to two results per input byte: an address record, then a status.
   typedef struct packed {
      logic [1:0] num;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== rtl/dra_parser.sv =====
module dra_parser #(
   parameter int MAX_PACKET_BYTES = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_accept,
   input  logic [7:0]        data_byte,
   input  logic              last_byte,
   output dra_pkg::push_type push_out
);
   import dra_pkg::*;

   localparam logic [3:0] PH_HDR    = 4'd0;
   localparam logic [3:0] PH_QLEN   = 4'd1;
   localparam logic [3:0] PH_QLABEL = 4'd2;
   localparam logic [3:0] PH_QFIX   = 4'd3;
   localparam logic [3:0] PH_AFIRST = 4'd4;
   localparam logic [3:0] PH_APTR   = 4'd5;
   localparam logic [3:0] PH_ALABEL = 4'd6;
   localparam logic [3:0] PH_ANEXT  = 4'd7;
   localparam logic [3:0] PH_AFIX   = 4'd8;
   localparam logic [3:0] PH_ADATA  = 4'd9;
   localparam logic [3:0] PH_DONE   = 4'd10;
   localparam logic [3:0] PH_ERR    = 4'd11;

   localparam logic [9:0]  POS_MAX   = 10'd1023;
   localparam logic [10:0] POS_LIMIT = 11'(MAX_PACKET_BYTES);

   logic [3:0]  phase_ff, phase_in;
   logic [9:0]  pos_ff, pos_in;
   logic [15:0] fc_ff, fc_in;
   logic [15:0] qtotal_ff, qtotal_in;
   logic [15:0] aleft_ff, aleft_in;
   logic [15:0] rtype_ff, rtype_in;
   logic [15:0] rlen_ff, rlen_in;
   logic [63:0] shup_ff, shup_in;
   logic [63:0] shlo_ff, shlo_in;
   logic [2:0]  err_ff, err_in;

   logic        addr_hit;
   result_type  addr_res;
   result_type  stat_res;
   logic [2:0]  status;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      fc_in     = fc_ff;
      qtotal_in = qtotal_ff;
      aleft_in  = aleft_ff;
      rtype_in  = rtype_ff;
      rlen_in   = rlen_ff;
      shup_in   = shup_ff;
      shlo_in   = shlo_ff;
      err_in    = err_ff;
      addr_hit  = 1'b0;
      addr_res  = '0;
      stat_res  = '0;
      status    = ST_OK;

      unique case (phase_ff)
         PH_HDR: begin
            if (pos_ff == 10'd2 && (!data_byte[7] || data_byte[6:3] != 4'd0) &&
                err_in == ST_OK) begin
               err_in = ST_BAD_FLAGS;
            end
            if (pos_ff == 10'd3 && data_byte[3:0] != 4'd0 && err_in == ST_OK) begin
               err_in = ST_BAD_FLAGS;
            end
            if (pos_ff == 10'd4) qtotal_in = {data_byte, 8'h00};
            if (pos_ff == 10'd5) qtotal_in = qtotal_ff | {8'h00, data_byte};
            if (pos_ff == 10'd6) aleft_in = {data_byte, 8'h00};
            if (pos_ff == 10'd7) aleft_in = aleft_ff | {8'h00, data_byte};
            if (pos_ff >= 10'd11) begin
               if (err_in == ST_OK && qtotal_in != 16'd1) err_in = ST_QCOUNT;
               phase_in = (err_in != ST_OK) ? PH_ERR : PH_QLEN;
            end
         end
         PH_QLEN: begin
            if (data_byte == 8'd0) begin
               phase_in = PH_QFIX;
               fc_in    = 16'd4;
            end else if (data_byte[7:6] != 2'b00) begin
               if (err_in == ST_OK) err_in = ST_COMPRESSED;
               phase_in = PH_ERR;
            end else begin
               phase_in = PH_QLABEL;
               fc_in    = {8'h00, data_byte};
            end
         end
         PH_QLABEL: begin
            fc_in = fc_ff - 16'd1;
            if (fc_in == 16'd0) phase_in = PH_QLEN;
         end
         PH_QFIX: begin
            fc_in = fc_ff - 16'd1;
            if (fc_in == 16'd0) phase_in = (aleft_ff == 16'd0) ? PH_DONE : PH_AFIRST;
         end
         PH_AFIRST: begin
            if (data_byte[7:6] == 2'b11) begin
               phase_in = PH_APTR;
            end else if (data_byte == 8'd0) begin
               phase_in = PH_AFIX;
               fc_in    = 16'd10;
            end else begin
               phase_in = PH_ALABEL;
               fc_in    = {8'h00, data_byte};
            end
         end
         PH_APTR: begin
            phase_in = PH_AFIX;
            fc_in    = 16'd10;
         end
         PH_ALABEL: begin
            fc_in = fc_ff - 16'd1;
            if (fc_in == 16'd0) phase_in = PH_ANEXT;
         end
         PH_ANEXT: begin
            if (data_byte == 8'd0) begin
               phase_in = PH_AFIX;
               fc_in    = 16'd10;
            end else begin
               phase_in = PH_ALABEL;
               fc_in    = {8'h00, data_byte};
            end
         end
         PH_AFIX: begin
            // countdown 10..1 walks type, class, ttl, rdlength
            if (fc_ff[3:0] == 4'd10) rtype_in = {data_byte, 8'h00};
            if (fc_ff[3:0] == 4'd9)  rtype_in = rtype_ff | {8'h00, data_byte};
            if (fc_ff[3:0] == 4'd2)  rlen_in  = {data_byte, 8'h00};
            if (fc_ff[3:0] == 4'd1)  rlen_in  = rlen_ff | {8'h00, data_byte};
            fc_in = fc_ff - 16'd1;
            if (fc_in == 16'd0) begin
               if (rlen_in == 16'd0) begin
                  aleft_in = aleft_ff - 16'd1;
                  phase_in = (aleft_in == 16'd0) ? PH_DONE : PH_AFIRST;
               end else begin
                  phase_in = PH_ADATA;
                  fc_in    = rlen_in;
                  shup_in  = '0;
                  shlo_in  = '0;
               end
            end
         end
         PH_ADATA: begin
            shup_in = {shup_ff[55:0], shlo_ff[63:56]};
            shlo_in = {shlo_ff[55:0], data_byte};
            fc_in   = fc_ff - 16'd1;
            if (fc_in == 16'd0) begin
               if (rtype_ff == RTYPE_A && rlen_ff == RLEN_A) begin
                  addr_hit                = 1'b1;
                  addr_res.result_kind    = KIND_IPV4;
                  addr_res.address_lower  = {32'h0, shlo_in[31:0]};
               end else if (rtype_ff == RTYPE_AAAA && rlen_ff == RLEN_AAAA) begin
                  addr_hit                = 1'b1;
                  addr_res.result_kind    = KIND_IPV6;
                  addr_res.address_upper  = shup_in;
                  addr_res.address_lower  = shlo_in;
               end
               aleft_in = aleft_ff - 16'd1;
               phase_in = (aleft_in == 16'd0) ? PH_DONE : PH_AFIRST;
            end
         end
         default: begin
         end
      endcase

      if (last_byte) begin
         if (pos_ff <= 10'd11)        status = ST_SHORT;
         else if (err_in != ST_OK)    status = err_in;
         else if (phase_in == PH_DONE) status = ST_OK;
         else                         status = ST_TRUNCATED;
         stat_res.result_kind  = KIND_STATUS;
         stat_res.parse_status = status;
         stat_res.last_result  = 1'b1;
         phase_in  = PH_HDR;
         pos_in    = '0;
         fc_in     = '0;
         qtotal_in = '0;
         aleft_in  = '0;
         rtype_in  = '0;
         rlen_in   = '0;
         err_in    = ST_OK;
      end else begin
         // oversized packet: flag truncation at the size limit
         if (({1'b0, pos_ff} + 11'd1) >= POS_LIMIT && err_in == ST_OK) begin
            err_in = ST_TRUNCATED;
            if (phase_in != PH_HDR) phase_in = PH_ERR;
         end
         if (pos_ff < POS_MAX) pos_in = pos_ff + 10'd1;
      end
   end

   always_comb begin
      push_out = '0;
      if (in_accept) begin
         push_out.num = {1'b0, addr_hit} + {1'b0, last_byte};
         if (addr_hit) begin
            push_out.first  = addr_res;
            push_out.second = stat_res;
         end else begin
            push_out.first  = stat_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR;
         pos_ff    <= '0;
         fc_ff     <= '0;
         qtotal_ff <= '0;
         aleft_ff  <= '0;
         rtype_ff  <= '0;
         rlen_ff   <= '0;
         err_ff    <= ST_OK;
      end else if (in_accept) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         fc_ff     <= fc_in;
         qtotal_ff <= qtotal_in;
         aleft_ff  <= aleft_in;
         rtype_ff  <= rtype_in;
         rlen_ff   <= rlen_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         shup_ff <= shup_in;
         shlo_ff <= shlo_in;
      end
   end

   a_packet_restart: assert property (@(posedge clock) disable iff (reset)
      (in_accept && last_byte) |=> (pos_ff == 10'd0 && phase_ff == PH_HDR && err_ff == ST_OK))
      else $error("parser did not restart after packet end");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push_out.num == 2'd2) |->
         (push_out.first.result_kind != KIND_STATUS && push_out.second.last_result))
      else $error("address result must precede the closing status");

endmodule

// ===== rtl/dra_result_queue.sv =====
module dra_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  dra_pkg::push_type   push_in,
   output logic                almost_full,
   output logic                out_valid,
   input  logic                out_stall,
   output dra_pkg::result_type out_result
);
   import dra_pkg::*;

   result_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [QUEUE_PTR_W-1:0] wr_ptr_next;
   logic                   pop;

   assign out_valid   = (count_ff != '0);
   assign out_result  = entries_ff[rd_ptr_ff];
   assign pop         = out_valid && !out_stall;
   // keep room for a two-result byte
   assign almost_full = (count_ff > QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign wr_ptr_next = wr_ptr_ff + QUEUE_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push_in.num);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + QUEUE_CNT_W'(push_in.num) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_in.num != 2'd0) entries_ff[wr_ptr_ff] <= push_in.first;
      if (push_in.num == 2'd2) entries_ff[wr_ptr_next] <= push_in.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_pair_count: assert property (@(posedge clock) disable iff (reset)
      (push_in.num == 2'd2 && !pop) |=>
         (count_ff == QUEUE_CNT_W'($past(count_ff) + QUEUE_CNT_W'(2))))
      else $error("result queue lost an entry of a pair");

endmodule

// ===== rtl/dns_response_address_extractor_top.sv =====
// Channel | Direction | Ports                                    | Transfer when
// req     | in        | req_data_byte, req_last_byte             | req_valid && !req_stall
// rsp     | out       | rsp_result_kind, rsp_address_upper/lower,| rsp_valid && !rsp_stall
//         |           | rsp_parse_status, rsp_last_result        |
//
// One byte per clock while req_stall is low: each byte updates the parser registers in the cycle of its transfer.
// A result is written into the queue register file, and rsp shows it from there.
// A byte can yield two results (address, then status); a four-entry queue holds them.
// req_stall rises while fewer than two queue entries are free, and only then.
// Reset is synchronous, active high; there is no clearing pass.
module dns_response_address_extractor_top #(
   parameter int MAX_PACKET_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // result stream
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [63:0] rsp_address_upper,
   output logic [63:0] rsp_address_lower,
   output logic [2:0]  rsp_parse_status,
   output logic        rsp_last_result
);
   import dra_pkg::*;

   logic       req_accept;
   push_type   push;
   result_type head;

   // byte transfer: valid with no stall
   assign req_accept = req_valid && !req_stall;

   // header check, question walk and answer walk; results go straight to the queue
   dra_parser #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .push_out  (push)
   );

   // result register file; parts the two sides, input stalls only once it is nearly full
   dra_result_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_in     (push),
      .almost_full (req_stall),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_result  (head)
   );

   assign rsp_result_kind   = head.result_kind;
   assign rsp_address_upper = head.address_upper;
   assign rsp_address_lower = head.address_lower;
   assign rsp_parse_status  = head.parse_status;
   assign rsp_last_result   = head.last_result;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
   import dra_pkg::*;

   localparam int MAX_BYTES  = 512;
   localparam int WIRE_ITEMS = 1750;

   // Parser phases of the local model
   typedef enum logic [3:0] {
      HDR_BYTES, QNAME_LEN, QNAME_LABEL, QFIXED, ANAME_FIRST, ANAME_PTR,
      ANAME_LABEL, ANAME_NEXT, AFIXED, ADATA, PKT_DONE, PKT_ERROR
   } dns_phase_type;

   // Receiver stall behaviors
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } wire_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [63:0] rsp_address_upper;
   logic [63:0] rsp_address_lower;
   logic [2:0]  rsp_parse_status;
   logic        rsp_last_result;

   dns_response_address_extractor_top #(
      .MAX_PACKET_BYTES (MAX_BYTES)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_address_upper (rsp_address_upper),
      .rsp_address_lower (rsp_address_lower),
      .rsp_parse_status  (rsp_parse_status),
      .rsp_last_result   (rsp_last_result)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Shared state
   // ------------------------------------------------------------------
   wire_byte_type wire_bytes[$];   // bytes waiting to be offered
   logic [7:0]  pkt_bytes[$];      // packet under construction
   result_type  records_due[$];    // predicted results, oldest first
   int          wire_total = 0;
   int          items_accepted = 0;
   int          mismatch_count = 0;
   logic        holdoff_active = 1'b0;
   logic        winding_down = 1'b0;

   // Local parser model state
   dns_phase_type phase;
   logic [9:0]  pos;
   logic [15:0] countdown;
   logic [15:0] qcount;
   logic [15:0] ans_left;
   logic [15:0] rtype;
   logic [15:0] rlen;
   logic [63:0] shift_hi;
   logic [63:0] shift_lo;
   logic [2:0]  err;

   // ------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------
   task automatic clear_parser();
      phase     = HDR_BYTES;
      pos       = '0;
      countdown = '0;
      qcount    = '0;
      ans_left  = '0;
      rtype     = '0;
      rlen      = '0;
      shift_hi  = '0;
      shift_lo  = '0;
      err       = ST_OK;
   endtask

   task automatic note_result(input logic [1:0] kind, input logic [63:0] up,
                              input logic [63:0] lo, input logic [2:0] st,
                              input logic lastr);
      result_type r;
      r.result_kind   = kind;
      r.address_upper = up;
      r.address_lower = lo;
      r.parse_status  = st;
      r.last_result   = lastr;
      records_due.push_back(r);
   endtask

   task automatic close_answer();
      ans_left = ans_left - 16'd1;
      phase    = (ans_left == 16'd0) ? PKT_DONE : ANAME_FIRST;
   endtask

   task automatic open_fixed();
      phase     = AFIXED;
      countdown = 16'd10;
   endtask

   // One byte through the parser; queues any address and status it yields.
   task automatic walk_dns_byte(input logic [7:0] b, input logic lastb);
      logic [9:0] p;
      logic [3:0] k;
      logic [2:0] st;
      p = pos;
      case (phase)
         HDR_BYTES: begin
            if (p == 10'd2 && (!b[7] || b[6:3] != 4'd0) && err == ST_OK) err = ST_BAD_FLAGS;
            if (p == 10'd3 && b[3:0] != 4'd0 && err == ST_OK) err = ST_BAD_FLAGS;
            if (p == 10'd4) qcount = {b, 8'h00};
            if (p == 10'd5) qcount[7:0] = b;
            if (p == 10'd6) ans_left = {b, 8'h00};
            if (p == 10'd7) ans_left[7:0] = b;
            if (p >= 10'd11) begin
               if (err == ST_OK && qcount != 16'd1) err = ST_QCOUNT;
               phase = (err != ST_OK) ? PKT_ERROR : QNAME_LEN;
            end
         end
         QNAME_LEN: begin
            if (b == 8'd0) begin
               phase     = QFIXED;
               countdown = 16'd4;
            end else if (b[7:6] != 2'b00) begin
               if (err == ST_OK) err = ST_COMPRESSED;
               phase = PKT_ERROR;
            end else begin
               phase     = QNAME_LABEL;
               countdown = {8'h00, b};
            end
         end
         QNAME_LABEL: begin
            countdown = countdown - 16'd1;
            if (countdown == 16'd0) phase = QNAME_LEN;
         end
         QFIXED: begin
            countdown = countdown - 16'd1;
            if (countdown == 16'd0) phase = (ans_left == 16'd0) ? PKT_DONE : ANAME_FIRST;
         end
         ANAME_FIRST: begin
            if (b[7:6] == 2'b11) phase = ANAME_PTR;
            else if (b == 8'd0) open_fixed();
            else begin
               phase     = ANAME_LABEL;
               countdown = {8'h00, b};
            end
         end
         ANAME_PTR: open_fixed();
         ANAME_LABEL: begin
            countdown = countdown - 16'd1;
            if (countdown == 16'd0) phase = ANAME_NEXT;
         end
         ANAME_NEXT: begin
            if (b == 8'd0) open_fixed();
            else begin
               phase     = ANAME_LABEL;
               countdown = {8'h00, b};
            end
         end
         AFIXED: begin
            // type at offsets 0..1, rdlength at 8..9 of the fixed part
            k = 4'd10 - countdown[3:0];
            if (k == 4'd0) rtype = {b, 8'h00};
            if (k == 4'd1) rtype[7:0] = b;
            if (k == 4'd8) rlen = {b, 8'h00};
            if (k == 4'd9) rlen[7:0] = b;
            countdown = countdown - 16'd1;
            if (countdown == 16'd0) begin
               if (rlen == 16'd0) close_answer();
               else begin
                  phase     = ADATA;
                  countdown = rlen;
                  shift_hi  = '0;
                  shift_lo  = '0;
               end
            end
         end
         ADATA: begin
            shift_hi  = {shift_hi[55:0], shift_lo[63:56]};
            shift_lo  = {shift_lo[55:0], b};
            countdown = countdown - 16'd1;
            if (countdown == 16'd0) begin
               if (rtype == RTYPE_A && rlen == RLEN_A)
                  note_result(KIND_IPV4, 64'd0, {32'd0, shift_lo[31:0]}, ST_OK, 1'b0);
               else if (rtype == RTYPE_AAAA && rlen == RLEN_AAAA)
                  note_result(KIND_IPV6, shift_hi, shift_lo, ST_OK, 1'b0);
               close_answer();
            end
         end
         default: ;
      endcase

      if (lastb) begin
         if (p <= 10'd11) st = ST_SHORT;
         else if (err != ST_OK) st = err;
         else if (phase == PKT_DONE) st = ST_OK;
         else st = ST_TRUNCATED;
         note_result(KIND_STATUS, 64'd0, 64'd0, st, 1'b1);
         clear_parser();
      end else begin
         // Oversized packet: flagged once the size limit is reached unmarked
         if (int'(p) + 1 >= MAX_BYTES && err == ST_OK) begin
            err = ST_TRUNCATED;
            if (phase != HDR_BYTES) phase = PKT_ERROR;
         end
         if (pos < 10'd1023) pos = pos + 10'd1;
      end
   endtask

   // ------------------------------------------------------------------
   // Packet builders
   // ------------------------------------------------------------------
   task automatic add_random(input int n);
      repeat (n) pkt_bytes.push_back(8'($urandom));
   endtask

   // Legal header: QR set, opcode and rcode zero, other flag bits random.
   task automatic add_header(input logic [15:0] qd, input logic [15:0] an);
      add_random(2);
      pkt_bytes.push_back({1'b1, 4'b0000, 3'($urandom)});
      pkt_bytes.push_back({4'($urandom), 4'h0});
      pkt_bytes.push_back(qd[15:8]);
      pkt_bytes.push_back(qd[7:0]);
      pkt_bytes.push_back(an[15:8]);
      pkt_bytes.push_back(an[7:0]);
      add_random(4);
   endtask

   // Label run ending in the root byte; long labels only where allowed.
   task automatic add_name(input int labels, input logic long_ok);
      int len;
      for (int i = 0; i < labels; i++) begin
         if (long_ok && $urandom_range(0, 24) == 0)
            len = (i == 0) ? $urandom_range(64, 191) : $urandom_range(64, 255);
         else
            len = $urandom_range(1, 8);
         pkt_bytes.push_back(8'(len));
         add_random(len);
      end
      pkt_bytes.push_back(8'h00);
   endtask

   task automatic add_answer();
      int          r;
      logic [15:0] ty;
      logic [15:0] len;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         pkt_bytes.push_back({2'b11, 6'($urandom)});
         add_random(1);
      end else if (r < 55) pkt_bytes.push_back(8'h00);
      else add_name($urandom_range(1, 2), 1'b1);

      r = $urandom_range(0, 99);
      if (r < 35) begin
         ty = RTYPE_A;    len = RLEN_A;
      end else if (r < 65) begin
         ty = RTYPE_AAAA; len = RLEN_AAAA;
      end else if (r < 72) begin
         ty = RTYPE_A;
         len = 16'($urandom_range(0, 5));
         if (len == RLEN_A) len = 16'd6;
      end else if (r < 78) begin
         ty = RTYPE_AAAA;
         len = 16'($urandom_range(0, 20));
         if (len == RLEN_AAAA) len = 16'd3;
      end else if (r < 85) begin
         // right low byte, nonzero high byte
         ty  = {8'($urandom_range(1, 255)), ($urandom_range(0, 1) == 0) ? 8'd1 : 8'd28};
         len = ($urandom_range(0, 1) == 0) ? RLEN_A : RLEN_AAAA;
      end else begin
         ty = 16'($urandom);
         if (ty == RTYPE_A || ty == RTYPE_AAAA) ty = 16'd5;
         len = 16'($urandom_range(0, 6));
      end
      pkt_bytes.push_back(ty[15:8]);
      pkt_bytes.push_back(ty[7:0]);
      add_random(6);                     // class and TTL
      pkt_bytes.push_back(len[15:8]);
      pkt_bytes.push_back(len[7:0]);
      add_random(int'(len));
   endtask

   // Header, one question, some answers, optional trailing bytes.
   task automatic add_response(input logic [15:0] qd);
      logic [15:0] an;
      int          n_rec;
      an    = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      n_rec = (an > 16'd4) ? $urandom_range(0, 4) : int'(an);
      add_header(qd, an);
      add_name($urandom_range(0, 3), 1'b0);
      add_random(4);
      repeat (n_rec) add_answer();
      if ($urandom_range(0, 3) == 0) add_random($urandom_range(1, 3));
   endtask

   task automatic send_packet();
      wire_byte_type item;
      for (int i = 0; i < pkt_bytes.size(); i++) begin
         item.data = pkt_bytes[i];
         item.last = (i == pkt_bytes.size() - 1);
         wire_bytes.push_back(item);
      end
      wire_total += pkt_bytes.size();
      pkt_bytes.delete();
   endtask

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin : stimulus
      int          r;
      int          cut;
      logic        oversize_sent;
      logic [15:0] qd;
      oversize_sent = 1'b0;
      clear_parser();

      // Directed: one-byte packet, bare 12-byte header, smallest clean packet.
      pkt_bytes.push_back(8'hFF);
      send_packet();
      add_header(16'd1, 16'd0);
      send_packet();
      add_header(16'd1, 16'd0);
      pkt_bytes.push_back(8'h00);
      add_random(4);
      send_packet();

      while (wire_total < WIRE_ITEMS) begin
         r = $urandom_range(0, 99);
         if (!oversize_sent && wire_total > 600) begin
            // Oversized: one A record whose rdata runs past the size limit
            oversize_sent = 1'b1;
            add_header(16'd1, 16'd1);
            pkt_bytes.push_back(8'h00);
            add_random(4);
            pkt_bytes.push_back(8'hC0);
            pkt_bytes.push_back(8'h0C);
            pkt_bytes.push_back(RTYPE_A[15:8]);
            pkt_bytes.push_back(RTYPE_A[7:0]);
            add_random(6);
            pkt_bytes.push_back(8'h02);
            pkt_bytes.push_back(8'h00);
            add_random(520);
         end else if (r < 60) begin
            add_response(16'd1);
            // early end now and then
            if ($urandom_range(0, 7) == 0 && pkt_bytes.size() > 13) begin
               cut = $urandom_range(13, pkt_bytes.size() - 1);
               while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
            end
         end else if (r < 70) begin
            add_response(16'd1);
            case ($urandom_range(0, 2))
               0:       pkt_bytes[2] = pkt_bytes[2] & 8'h7F;
               1:       pkt_bytes[2] = pkt_bytes[2] | {1'b0, 4'($urandom_range(1, 15)), 3'b000};
               default: pkt_bytes[3] = pkt_bytes[3] | 8'($urandom_range(1, 15));
            endcase
         end else if (r < 78) begin
            case ($urandom_range(0, 2))
               0:       qd = 16'd0;
               1:       qd = 16'($urandom_range(2, 5));
               default: qd = 16'($urandom_range(2, 65535));
            endcase
            add_response(qd);
         end else if (r < 86) begin
            // question name with a pointer or reserved label type
            add_header(16'd1, 16'($urandom_range(0, 2)));
            repeat ($urandom_range(0, 1)) begin
               cut = $urandom_range(1, 8);
               pkt_bytes.push_back(8'(cut));
               add_random(cut);
            end
            pkt_bytes.push_back(8'($urandom_range(64, 255)));
            add_random($urandom_range(0, 10));
         end else if (r < 93) begin
            add_random($urandom_range(1, 30));
         end else begin
            add_random($urandom_range(1, 12));
         end
         send_packet();
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < wire_total || records_due.size() != 0) @(posedge clock);
      winding_down = 1'b1;
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && records_due.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Byte driver: bursts with random gaps; a transfer feeds the model.
   // ------------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin : byte_driver
      wire_byte_type nxt;
      logic          holding;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         holding = req_valid;
         if (req_valid && !req_stall) begin
            walk_dns_byte(req_data_byte, req_last_byte);
            items_accepted++;
            holding = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               // keep feeding while the receiver is held off
               if (holdoff_active || $urandom_range(0, 3) == 0) gap_left = 0;
               else gap_left = $urandom_range(1, 12);
            end
         end else if (!req_valid && gap_left > 0) begin
            gap_left--;
         end
         // payload only changes once the previous transfer has happened
         if (!holding && gap_left == 0 && wire_bytes.size() > 0) begin
            nxt = wire_bytes.pop_front();
            req_data_byte <= nxt.data;
            req_last_byte <= nxt.last;
            req_valid     <= 1'b1;
         end else if (!holding) begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver stall pattern, with two long hold-offs to fill the block.
   // ------------------------------------------------------------------
   int             cycle_count = 0;
   int             mode_left = 0;
   int             holdoff_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   always @(posedge clock) begin : rsp_pattern
      logic stall_next;
      stall_next = 1'b0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycle_count++;
         if (winding_down) begin
            stall_next = 1'b0;
         end else if (holdoff_left > 0) begin
            holdoff_left--;
            stall_next     = (holdoff_left != 0);
            holdoff_active = stall_next;
         end else if (cycle_count == 1500 || cycle_count == 3000) begin
            holdoff_left   = 300;
            holdoff_active = 1'b1;
            stall_next     = 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
               STALL_NONE:  stall_next = 1'b0;
               STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
               STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
               default:     stall_next = (cycle_count % 2 == 0);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: each transfer against the oldest predicted result.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (records_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: kind %0d upper %h lower %h status %0d last %0b",
                        rsp_result_kind, rsp_address_upper, rsp_address_lower,
                        rsp_parse_status, rsp_last_result);
         end else begin
            want = records_due.pop_front();
            if (want.result_kind !== rsp_result_kind ||
                want.address_upper !== rsp_address_upper ||
                want.address_lower !== rsp_address_lower ||
                want.parse_status !== rsp_parse_status ||
                want.last_result !== rsp_last_result) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: want kind %0d upper %h lower %h status %0d last %0b",
                           want.result_kind, want.address_upper, want.address_lower,
                           want.parse_status, want.last_result);
                  $display("          got  kind %0d upper %h lower %h status %0d last %0b",
                           rsp_result_kind, rsp_address_upper, rsp_address_lower,
                           rsp_parse_status, rsp_last_result);
               end
            end
         end
      end
   end

endmodule
